// ----- hdl/stu_pkg.sv -----
// ============================================================================
// stu_pkg: shared types and constants for the sphere subdivide unit
// Fixed point format, payload structs and the triangle packing helper.
// ============================================================================
`default_nettype none

package stu_pkg;

    localparam int FRAC_BITS = 14;
    localparam int COMP_W    = 16;
    localparam int SUM_W     = COMP_W + 1;
    localparam int SQ_W      = 2 * COMP_W + 1;
    localparam int LEN_W     = SQ_W + 2;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam int NUM_STEPS = FRAC_BITS + 1;
    localparam int ACC_W     = 2 * FRAC_BITS + 40;
    localparam int LANE_LAT  = NUM_STEPS + 2;
    localparam int VTX_DLY   = LANE_LAT + 2;
    localparam int NUM_VTX   = 3;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vtx_t;

    typedef struct packed {
        comp_t ax;
        comp_t ay;
        comp_t az;
        comp_t bx;
        comp_t by;
        comp_t bz;
        comp_t cx;
        comp_t cy;
        comp_t cz;
    } req_t;

    typedef struct packed {
        comp_t p0x;
        comp_t p0y;
        comp_t p0z;
        comp_t p1x;
        comp_t p1y;
        comp_t p1z;
        comp_t p2x;
        comp_t p2y;
        comp_t p2z;
        logic  final_piece;
    } rsp_t;

    function automatic rsp_t make_rsp(vtx_t p, vtx_t q, vtx_t r, logic last);
        rsp_t o;
        o.p0x = p.x;
        o.p0y = p.y;
        o.p0z = p.z;
        o.p1x = q.x;
        o.p1y = q.y;
        o.p1z = q.z;
        o.p2x = r.x;
        o.p2y = r.y;
        o.p2z = r.z;
        o.final_piece = last;
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/stu_norm_lane.sv -----
// ============================================================================
// stu_norm_lane: one normalized component
// Pipelined bit-per-stage search for round(|s| * 2^F / sqrt(len2)).
// ============================================================================
`default_nettype none

module stu_norm_lane (
    input  wire logic                                clk,
    input  wire logic signed [stu_pkg::SUM_W-1:0]    s,
    input  wire logic        [stu_pkg::SQ_W-1:0]     sq,
    input  wire logic        [stu_pkg::LEN_W-1:0]    len2,
    output      stu_pkg::comp_t                      w
);

    typedef struct packed {
        logic signed [stu_pkg::ACC_W-1:0] t_acc;
        logic signed [stu_pkg::ACC_W-1:0] u_acc;
        logic signed [stu_pkg::ACC_W-1:0] b_lim;
        logic signed [stu_pkg::ACC_W-1:0] len;
        logic        [stu_pkg::Q_W-1:0]   q;
        logic                             zero;
        logic                             neg;
    } step_t;

    step_t          stage_reg [0:stu_pkg::NUM_STEPS];
    step_t          stage_next [0:stu_pkg::NUM_STEPS];
    stu_pkg::comp_t w_reg;
    stu_pkg::comp_t w_next;

    always_comb
    begin
        stage_next[0].len   = signed'(stu_pkg::ACC_W'(len2));
        stage_next[0].t_acc = signed'(stu_pkg::ACC_W'(len2));
        stage_next[0].u_acc = -signed'(stu_pkg::ACC_W'(len2));
        stage_next[0].b_lim = signed'(stu_pkg::ACC_W'(sq)) <<< (2 * stu_pkg::FRAC_BITS + 2);
        stage_next[0].q     = '0;
        stage_next[0].zero  = (len2 == '0);
        stage_next[0].neg   = s[stu_pkg::SUM_W-1];
    end

    for (genvar i = 0; i < stu_pkg::NUM_STEPS; i++)
    begin : g_step
        localparam int K = stu_pkg::FRAC_BITS - i;
        logic signed [stu_pkg::ACC_W-1:0] cand;

        always_comb
        begin
            cand = stage_reg[i].t_acc + (stage_reg[i].u_acc <<< (K + 2))
                 + (stage_reg[i].len <<< (2 * K + 2));
            stage_next[i+1] = stage_reg[i];
            if (cand <= stage_reg[i].b_lim)
            begin
                stage_next[i+1].t_acc = cand;
                stage_next[i+1].u_acc = stage_reg[i].u_acc + (stage_reg[i].len <<< (K + 1));
                stage_next[i+1].q[K]  = 1'b1;
            end
        end
    end

    always_comb
    begin
        logic [31:0] mag;
        mag = stage_reg[stu_pkg::NUM_STEPS].zero ? 32'd0
                                                 : 32'(stage_reg[stu_pkg::NUM_STEPS].q);
        if (stage_reg[stu_pkg::NUM_STEPS].neg)
        begin
            if (mag > 32'd32768)
                w_next = 16'sh8000;
            else
                w_next = stu_pkg::COMP_W'(-signed'(mag));
        end
        else
        begin
            if (mag > 32'd32767)
                w_next = 16'sh7fff;
            else
                w_next = stu_pkg::COMP_W'(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j <= stu_pkg::NUM_STEPS; j++)
        begin
            stage_reg[j] <= stage_next[j];
        end
        w_reg <= w_next;
    end

    assign w = w_reg;

endmodule

`default_nettype wire

// ----- hdl/stu_emit.sv -----
// ============================================================================
// stu_emit: merge stage and output sequencer
// Collect lane midpoints with the vertices and issue four triangles.
// ============================================================================
`default_nettype none

module stu_emit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  wire stu_pkg::vtx_t va,
    input  wire stu_pkg::vtx_t vb,
    input  wire stu_pkg::vtx_t vc,
    input  wire stu_pkg::vtx_t w0,
    input  wire stu_pkg::vtx_t w1,
    input  wire stu_pkg::vtx_t w2,
    output      stu_pkg::rsp_t rsp,
    output      logic          rsp_valid
);

    stu_pkg::vtx_t b_reg, c_reg, w0_reg, w1_reg, w2_reg;
    stu_pkg::vtx_t b_next, c_next, w0_next, w1_next, w2_next;
    stu_pkg::rsp_t rsp_reg, rsp_next;
    logic          valid_reg, valid_next;
    logic          active_reg, active_next;
    logic [1:0]    ph_reg, ph_next;

    always_comb
    begin
        b_next      = b_reg;
        c_next      = c_reg;
        w0_next     = w0_reg;
        w1_next     = w1_reg;
        w2_next     = w2_reg;
        rsp_next    = rsp_reg;
        valid_next  = 1'b0;
        active_next = active_reg;
        ph_next     = ph_reg;
        if (load)
        begin
            b_next      = vb;
            c_next      = vc;
            w0_next     = w0;
            w1_next     = w1;
            w2_next     = w2;
            rsp_next    = stu_pkg::make_rsp(va, w2, w1, 1'b0);
            valid_next  = 1'b1;
            active_next = 1'b1;
            ph_next     = 2'd1;
        end
        else if (active_reg)
        begin
            valid_next = 1'b1;
            ph_next    = ph_reg + 2'd1;
            case (ph_reg)
                2'd1:    rsp_next = stu_pkg::make_rsp(b_reg, w0_reg, w2_reg, 1'b0);
                2'd2:    rsp_next = stu_pkg::make_rsp(c_reg, w1_reg, w0_reg, 1'b0);
                default:
                begin
                    rsp_next    = stu_pkg::make_rsp(w0_reg, w1_reg, w2_reg, 1'b1);
                    active_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg   <= b_next;
        c_reg   <= c_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        w2_reg  <= w2_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            active_reg <= 1'b0;
            ph_reg     <= 2'd0;
        end
        else
        begin
            valid_reg  <= valid_next;
            active_reg <= active_next;
            ph_reg     <= ph_next;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = valid_reg;

endmodule

`default_nettype wire

// ----- hdl/sphere_triangle_subdivide_unit.sv -----
// ============================================================================
// sphere_triangle_subdivide_unit: one level of geodesic midpoint subdivision
// A request is a triangle on the unit sphere (three Q1.14 vertices). The
// unit forms the three normalized edge midpoints and issues four triangles:
// (a,w2,w1), (b,w0,w2), (c,w1,w0), (w0,w1,w2); the last carries final_piece.
//
// A request is taken on a rising edge with start high and busy low. busy
// rises after each request and holds off the next one, so requests are
// spaced to match the four results each produces. Requests overlap
// freely inside the pipeline.
// Each result appears on rsp for one cycle with rsp_valid high; the four
// results of a request come on consecutive cycles. The first result
// passes the request input register, the front-end sum and square stages,
// the lane input register, the bit-per-stage normalizer pipeline of nine
// component lanes (FRAC_BITS + 1 search stages each, FRAC_BITS = 14 for
// Q1.14), the lane output register and the merge register.
// Reset clears all valid flags and busy; no request is in flight after it.
// The receiver cannot stall rsp.
// ============================================================================
`default_nettype none

module sphere_triangle_subdivide_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output      logic          busy,
    input  wire stu_pkg::req_t req,
    output      stu_pkg::rsp_t rsp,
    output      logic          rsp_valid
);

    logic           in_valid_reg;
    stu_pkg::vtx_t  vin_reg [stu_pkg::NUM_VTX];
    logic [1:0]     gap_reg, gap_next;
    logic           accept;

    logic signed [stu_pkg::SUM_W-1:0] sum_reg [3][3];
    logic signed [stu_pkg::SUM_W-1:0] sum2_reg [3][3];
    logic        [stu_pkg::SQ_W-1:0]  sq_reg [3][3];
    logic        [stu_pkg::LEN_W-1:0] len2 [3];
    stu_pkg::comp_t                   wc [3][3];
    stu_pkg::vtx_t                    wv [3];

    stu_pkg::vtx_t dly_reg [stu_pkg::VTX_DLY][stu_pkg::NUM_VTX];
    logic          dly_valid_reg [stu_pkg::VTX_DLY];

    assign accept   = start && !busy;
    assign busy     = (gap_reg != 2'd0);
    assign gap_next = accept ? 2'd3 : ((gap_reg != 2'd0) ? gap_reg - 2'd1 : 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg      <= 2'd0;
            in_valid_reg <= 1'b0;
            for (int j = 0; j < stu_pkg::VTX_DLY; j++)
            begin
                dly_valid_reg[j] <= 1'b0;
            end
        end
        else
        begin
            gap_reg          <= gap_next;
            in_valid_reg     <= accept;
            dly_valid_reg[0] <= in_valid_reg;
            for (int j = 1; j < stu_pkg::VTX_DLY; j++)
            begin
                dly_valid_reg[j] <= dly_valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vin_reg[0] <= '{x: req.ax, y: req.ay, z: req.az};
            vin_reg[1] <= '{x: req.bx, y: req.by, z: req.bz};
            vin_reg[2] <= '{x: req.cx, y: req.cy, z: req.cz};
        end
        dly_reg[0] <= vin_reg;
        for (int j = 1; j < stu_pkg::VTX_DLY; j++)
        begin
            dly_reg[j] <= dly_reg[j-1];
        end
    end

    for (genvar m = 0; m < 3; m++)
    begin : g_mid
        localparam int P = (m == 0) ? 1 : 0;
        localparam int R = (m == 2) ? 1 : 2;
        stu_pkg::comp_t pc [3];
        stu_pkg::comp_t rc [3];

        assign pc[0] = vin_reg[P].x;
        assign pc[1] = vin_reg[P].y;
        assign pc[2] = vin_reg[P].z;
        assign rc[0] = vin_reg[R].x;
        assign rc[1] = vin_reg[R].y;
        assign rc[2] = vin_reg[R].z;

        assign len2[m] = stu_pkg::LEN_W'(sq_reg[m][0]) + stu_pkg::LEN_W'(sq_reg[m][1])
                       + stu_pkg::LEN_W'(sq_reg[m][2]);

        for (genvar k = 0; k < 3; k++)
        begin : g_comp
            logic signed [2*stu_pkg::SUM_W-1:0] prod;

            assign prod = sum_reg[m][k] * sum_reg[m][k];

            always_ff @(posedge clk)
            begin
                sum_reg[m][k]  <= stu_pkg::SUM_W'(pc[k]) + stu_pkg::SUM_W'(rc[k]);
                sum2_reg[m][k] <= sum_reg[m][k];
                sq_reg[m][k]   <= stu_pkg::SQ_W'(prod);
            end

            stu_norm_lane u_lane (
                .clk  (clk),
                .s    (sum2_reg[m][k]),
                .sq   (sq_reg[m][k]),
                .len2 (len2[m]),
                .w    (wc[m][k])
            );
        end

        assign wv[m] = '{x: wc[m][0], y: wc[m][1], z: wc[m][2]};
    end

    stu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (dly_valid_reg[stu_pkg::VTX_DLY-1]),
        .va        (dly_reg[stu_pkg::VTX_DLY-1][0]),
        .vb        (dly_reg[stu_pkg::VTX_DLY-1][1]),
        .vc        (dly_reg[stu_pkg::VTX_DLY-1][2]),
        .w0        (wv[0]),
        .w1        (wv[1]),
        .w2        (wv[2]),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

endmodule

`default_nettype wire

// ----- tb/tb_sphere_triangle_subdivide_unit.sv -----
// ----------------------------------------------------------------------------
// Sphere subdivide unit testbench
// Feeds triangles (directed corner cases, then random-vertex triangles and raw
// patterns) through the start/busy port, predicts the four output triangles
// of each request with an exact integer midpoint normalizer, and checks each
// strobed result in order against the predicted triangles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sphere_triangle_subdivide_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    stu_pkg::req_t  req;
    stu_pkg::rsp_t  rsp;
    logic           rsp_valid;

    stu_pkg::req_t  pending_reqs[$];
    stu_pkg::rsp_t  expected_tris[$];
    int             errors;
    int             cycles;
    int             idle_left;
    bit             feed_done;
    bit             quiet;

    sphere_triangle_subdivide_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .rsp      (rsp),
        .rsp_valid(rsp_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // round(|s| * 2^F / sqrt(len2)) with the sign of s, ties away from zero, saturated
    function automatic stu_pkg::comp_t unit_comp(longint s, longint unsigned len2);
        longint unsigned mag;
        logic [127:0]    lim;
        logic [127:0]    prod;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned t;
        longint          q;
        mag = (s < 0) ? -s : s;
        lim = (128'(4 * mag * mag)) << (2 * stu_pkg::FRAC_BITS);
        lo  = 0;
        hi  = 64'd1 << stu_pkg::FRAC_BITS;
        while (lo < hi)
        begin
            mid  = lo + (hi - lo + 1) / 2;
            t    = 2 * mid - 1;
            prod = 128'(t * t) * 128'(len2);
            if (prod <= lim)
                lo = mid;
            else
                hi = mid - 1;
        end
        q = (s < 0) ? -longint'(lo) : longint'(lo);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return stu_pkg::comp_t'(q);
    endfunction

    function automatic stu_pkg::vtx_t sphere_midpoint(stu_pkg::vtx_t p, stu_pkg::vtx_t r);
        stu_pkg::vtx_t   w;
        longint          sx;
        longint          sy;
        longint          sz;
        longint unsigned len2;
        sx   = longint'(p.x) + longint'(r.x);
        sy   = longint'(p.y) + longint'(r.y);
        sz   = longint'(p.z) + longint'(r.z);
        len2 = sx * sx + sy * sy + sz * sz;
        w    = '0;
        if (len2 != 0)
        begin
            w.x = unit_comp(sx, len2);
            w.y = unit_comp(sy, len2);
            w.z = unit_comp(sz, len2);
        end
        return w;
    endfunction

    function automatic stu_pkg::rsp_t tri_of(stu_pkg::vtx_t p, stu_pkg::vtx_t q,
                                             stu_pkg::vtx_t r, logic last);
        stu_pkg::rsp_t o;
        o = {p.x, p.y, p.z, q.x, q.y, q.z, r.x, r.y, r.z, last};
        return o;
    endfunction

    task automatic queue_req(stu_pkg::req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic queue_tri(stu_pkg::rsp_t t);
        expected_tris.insert(expected_tris.size(), t);
    endtask

    task automatic predict_subdivision(stu_pkg::req_t r);
        stu_pkg::vtx_t a;
        stu_pkg::vtx_t b;
        stu_pkg::vtx_t c;
        stu_pkg::vtx_t w0;
        stu_pkg::vtx_t w1;
        stu_pkg::vtx_t w2;
        a  = {r.ax, r.ay, r.az};
        b  = {r.bx, r.by, r.bz};
        c  = {r.cx, r.cy, r.cz};
        w0 = sphere_midpoint(b, c);
        w1 = sphere_midpoint(a, c);
        w2 = sphere_midpoint(a, b);
        queue_tri(tri_of(a, w2, w1, 1'b0));
        queue_tri(tri_of(b, w0, w2, 1'b0));
        queue_tri(tri_of(c, w1, w0, 1'b0));
        queue_tri(tri_of(w0, w1, w2, 1'b1));
    endtask

    function automatic stu_pkg::vtx_t rand_unit_vtx();
        stu_pkg::vtx_t v;
        int   x;
        int   y;
        int   z;
        int   m;
        x = $urandom_range(32768) - 16384;
        y = $urandom_range(32768) - 16384;
        z = $urandom_range(32768) - 16384;
        m = (x < 0 ? -x : x);
        if ((y < 0 ? -y : y) > m)
            m = (y < 0 ? -y : y);
        if ((z < 0 ? -z : z) > m)
            m = (z < 0 ? -z : z);
        if (m == 0)
            x = 16384;
        else if ($urandom_range(1))
        begin
            x = x * 16384 / m;
            y = y * 16384 / m;
            z = z * 16384 / m;
        end
        v.x = stu_pkg::comp_t'(x);
        v.y = stu_pkg::comp_t'(y);
        v.z = stu_pkg::comp_t'(z);
        return v;
    endfunction

    function automatic stu_pkg::req_t rand_req();
        stu_pkg::req_t r;
        stu_pkg::vtx_t a;
        stu_pkg::vtx_t b;
        stu_pkg::vtx_t c;
        int   kind;
        kind = $urandom_range(9);
        if (kind == 0)
            r = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        else
        begin
            a = rand_unit_vtx();
            b = rand_unit_vtx();
            c = rand_unit_vtx();
            if (kind == 1)
                b = {-a.x, -a.y, -a.z};
            if (kind == 2)
                c = a;
            r = {a, b, c};
        end
        return r;
    endfunction

    initial
    begin
        stu_pkg::req_t r;
        rst_n = 1'b0;
        queue_req({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0,
                   16'sd0, 16'sd0, 16'sd16384});
        queue_req({-16'sd16384, 16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0,
                   16'sd0, 16'sd0, -16'sd16384});
        queue_req({16'sd16384, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0,
                   16'sd0, 16'sd16384, 16'sd0});
        queue_req({16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, -16'sd16384,
                   16'sd0, 16'sd0, 16'sd16384});
        queue_req('0);
        queue_req('1);
        queue_req({9{16'h7fff}});
        queue_req({9{16'h8000}});
        queue_req({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                   16'h7fff, 16'h8000, 16'h7fff});
        queue_req({16'sd9459, 16'sd9459, 16'sd9459, -16'sd9459, 16'sd9459,
                   -16'sd9459, 16'sd9459, -16'sd9459, -16'sd9459});
        queue_req({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0,
                   16'sd0, 16'sd0, -16'sd1});
        queue_req({16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384,
                   16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384});
        queue_req({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                   16'h5555, 16'haaaa, 16'h5555});
        for (int i = 0; i < N_RANDOM; i++)
        begin
            r = rand_req();
            queue_req(r);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            req       <= '0;
            idle_left <= 0;
            feed_done <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                predict_subdivision(req);
            if (start && busy)
            begin
                // hold
            end
            else if (idle_left > 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (pending_reqs.size() == 0)
            begin
                start     <= 1'b0;
                feed_done <= 1'b1;
            end
            else
            begin
                if (pending_reqs.size() > 40 && $urandom_range(5) == 0)
                begin
                    start     <= 1'b0;
                    idle_left <= $urandom_range(7);
                end
                else
                begin
                    start <= 1'b1;
                    req   <= pending_reqs[0];
                    pending_reqs.delete(0);
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        stu_pkg::rsp_t want;
        if (rst_n && rsp_valid)
        begin
            if (expected_tris.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, rsp);
                errors++;
            end
            else
            begin
                want = expected_tris[0];
                expected_tris.delete(0);
                if (rsp !== want)
                begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, rsp);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        quiet  = 1'b0;
        while (!quiet && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
            if (feed_done && !start && expected_tris.size() == 0)
                quiet = 1'b1;
        end
        if (!quiet)
        begin
            $display("tb_sphere_triangle_subdivide_unit: errors");
        end
        else
        begin
            repeat (40) @(posedge clk);
            if (errors == 0)
                $display("tb_sphere_triangle_subdivide_unit: clean");
            else
                $display("tb_sphere_triangle_subdivide_unit: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
